[hdl/life_generation_step_unit_macros.svh]
// ----------------------------------------------------------------------------
// Life generation step unit assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LIFE_GENERATION_STEP_UNIT_MACROS_SVH
`define LIFE_GENERATION_STEP_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LGSU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lgsu assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LGSU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lgsu assertion failed");

`endif

[hdl/lgsu_pkg.sv]
// ----------------------------------------------------------------------------
// Life generation step package
// Grid geometry, operation and register codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lgsu_pkg;

    // Grid geometry.
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int X_W        = $clog2(MAX_WIDTH);
    localparam int Y_W        = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = Y_W + 1;
    localparam int ROWS_TOTAL = 2 * MAX_HEIGHT;
    localparam int DIM_W      = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);

    // Field and register widths.
    localparam int OP_W    = 2;
    localparam int COORD_W = 6;
    localparam int CFG_W   = 7;
    localparam int CNT_W   = 13;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // Register reset values.
    localparam logic [CFG_W-1:0] GRID_DIM_RESET = CFG_W'(30);

    // Configuration register indexes.
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    // Operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_STEP  = 2'd2
    } t_op;

    // Row selection for the memory read port.
    typedef enum logic [1:0] {
        SEL_CELL = 2'd0,
        SEL_UP   = 2'd1,
        SEL_MID  = 2'd2,
        SEL_DN   = 2'd3
    } t_row_sel;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CELL_RD,
        S_CELL_CMT,
        S_GEN_INIT,
        S_RD_UP,
        S_RD_MID,
        S_RD_DN,
        S_ROW_LOAD,
        S_CELLS,
        S_ROW_WR,
        S_DONE
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic     load_item;
        logic     rd_en;
        t_row_sel rd_sel;
        logic     cell_commit;
        logic     gen_init;
        logic     cap_up;
        logic     cap_mid;
        logic     cap_dn;
        logic     cell_step;
        logic     row_wr;
        logic     flip;
        logic     out_load;
    } t_dp_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            in_grid;
        logic            x_last;
        logic            y_last;
        logic            out_full;
    } t_dp_sts;

endpackage

[hdl/lgsu_ctrl.sv]
// ----------------------------------------------------------------------------
// Life generation step controller
// Sequences cell accesses and the row-by-row generation sweep.
// ----------------------------------------------------------------------------
module lgsu_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lgsu_pkg::t_dp_sts i_sts,
    output lgsu_pkg::t_dp_cmd o_cmd
);

    lgsu_pkg::t_state r_state;
    lgsu_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lgsu_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            lgsu_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = lgsu_pkg::S_DECODE;
                end
            end
            lgsu_pkg::S_DECODE: begin
                case (i_sts.op)
                    lgsu_pkg::OP_WRITE,
                    lgsu_pkg::OP_READ: begin
                        n_state = i_sts.in_grid ? lgsu_pkg::S_CELL_RD : lgsu_pkg::S_DONE;
                    end
                    lgsu_pkg::OP_STEP: begin
                        n_state = lgsu_pkg::S_GEN_INIT;
                    end
                    default: begin
                        n_state = lgsu_pkg::S_DONE;
                    end
                endcase
            end
            lgsu_pkg::S_CELL_RD:  n_state = lgsu_pkg::S_CELL_CMT;
            lgsu_pkg::S_CELL_CMT: n_state = lgsu_pkg::S_DONE;
            lgsu_pkg::S_GEN_INIT: n_state = lgsu_pkg::S_RD_UP;
            lgsu_pkg::S_RD_UP:    n_state = lgsu_pkg::S_RD_MID;
            lgsu_pkg::S_RD_MID:   n_state = lgsu_pkg::S_RD_DN;
            lgsu_pkg::S_RD_DN:    n_state = lgsu_pkg::S_ROW_LOAD;
            lgsu_pkg::S_ROW_LOAD: n_state = lgsu_pkg::S_CELLS;
            lgsu_pkg::S_CELLS: begin
                if (i_sts.x_last) begin
                    n_state = lgsu_pkg::S_ROW_WR;
                end
            end
            lgsu_pkg::S_ROW_WR: begin
                n_state = i_sts.y_last ? lgsu_pkg::S_DONE : lgsu_pkg::S_RD_UP;
            end
            lgsu_pkg::S_DONE: begin
                if (!i_sts.out_full) begin
                    n_state = lgsu_pkg::S_IDLE;
                end
            end
            default: n_state = lgsu_pkg::S_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd      = '0;
        o_cmd.rd_sel = lgsu_pkg::SEL_CELL;
        o_in_ready = 1'b0;
        case (r_state)
            lgsu_pkg::S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
            end
            lgsu_pkg::S_CELL_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = lgsu_pkg::SEL_CELL;
            end
            lgsu_pkg::S_CELL_CMT: o_cmd.cell_commit = 1'b1;
            lgsu_pkg::S_GEN_INIT: o_cmd.gen_init = 1'b1;
            lgsu_pkg::S_RD_UP: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = lgsu_pkg::SEL_UP;
            end
            lgsu_pkg::S_RD_MID: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = lgsu_pkg::SEL_MID;
                o_cmd.cap_up = 1'b1;
            end
            lgsu_pkg::S_RD_DN: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = lgsu_pkg::SEL_DN;
                o_cmd.cap_mid = 1'b1;
            end
            lgsu_pkg::S_ROW_LOAD: o_cmd.cap_dn = 1'b1;
            lgsu_pkg::S_CELLS:    o_cmd.cell_step = 1'b1;
            lgsu_pkg::S_ROW_WR: begin
                o_cmd.row_wr = 1'b1;
                o_cmd.flip   = i_sts.y_last;
            end
            lgsu_pkg::S_DONE: o_cmd.out_load = !i_sts.out_full;
            default: o_cmd = '0;
        endcase
    end

endmodule

[hdl/lgsu_dp.sv]
// ----------------------------------------------------------------------------
// Life generation step datapath
// Two-bank row-wide grid memory, row buffers, neighbor evaluator, counters,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
`include "life_generation_step_unit_macros.svh"

module lgsu_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [lgsu_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [lgsu_pkg::OP_W-1:0]      i_op,
    input  logic [lgsu_pkg::COORD_W-1:0]   i_col,
    input  logic [lgsu_pkg::COORD_W-1:0]   i_row,
    input  logic                           i_cell_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_cell_out,
    output logic [lgsu_pkg::CNT_W-1:0]     o_change_count,
    input  lgsu_pkg::t_dp_cmd              i_cmd,
    output lgsu_pkg::t_dp_sts              o_sts
);

    localparam int MW = lgsu_pkg::MAX_WIDTH;

    // Configuration and control registers.
    logic [lgsu_pkg::CFG_W-1:0]      r_grid_width;
    logic [lgsu_pkg::CFG_W-1:0]      r_grid_height;
    logic                            r_cur_bank;
    logic [lgsu_pkg::ROWS_TOTAL-1:0] r_row_vld;
    logic                            r_out_valid;

    // Item and working registers.
    logic [lgsu_pkg::OP_W-1:0]    r_op;
    logic [lgsu_pkg::COORD_W-1:0] r_col;
    logic [lgsu_pkg::COORD_W-1:0] r_row;
    logic                         r_cell_in;
    logic [lgsu_pkg::X_W-1:0]     r_x;
    logic [lgsu_pkg::Y_W-1:0]     r_y;
    logic [MW-1:0]                r_up;
    logic [MW-1:0]                r_mid;
    logic [MW-1:0]                r_dn;
    logic [MW-1:0]                r_new;
    logic [lgsu_pkg::CNT_W-1:0]   r_count;
    logic                         r_res_cell;
    logic                         r_out_cell;
    logic [lgsu_pkg::CNT_W-1:0]   r_out_count;

    // Grid memory and its registered read port.
    logic [MW-1:0] r_grid_mem [lgsu_pkg::ROWS_TOTAL];
    logic [MW-1:0] r_rd_data;
    logic          r_rd_vld;

    logic [lgsu_pkg::DIM_W-1:0]  w_eff;
    logic [lgsu_pkg::DIM_W-1:0]  h_eff;
    logic [lgsu_pkg::X_W-1:0]    xm;
    logic [lgsu_pkg::X_W-1:0]    xp;
    logic [lgsu_pkg::Y_W-1:0]    ym;
    logic [lgsu_pkg::Y_W-1:0]    yp;
    logic [lgsu_pkg::Y_W-1:0]    rd_row;
    logic [lgsu_pkg::ADDR_W-1:0] rd_addr;
    logic [lgsu_pkg::ADDR_W-1:0] wr_addr;
    logic [MW-1:0]               wr_data;
    logic                        mem_we;
    logic [MW-1:0]               rd_row_eff;
    logic [lgsu_pkg::X_W-1:0]    col_idx;
    logic [3:0]                  n_live;
    logic                        self_bit;
    logic                        next_bit;

    // Effective grid size: zero acts as one, large values clamp to the maximum.
    always_comb begin
        if (r_grid_width == '0) begin
            w_eff = lgsu_pkg::DIM_W'(1);
        end else if (32'(r_grid_width) > 32'(lgsu_pkg::MAX_WIDTH)) begin
            w_eff = lgsu_pkg::DIM_W'(lgsu_pkg::MAX_WIDTH);
        end else begin
            w_eff = lgsu_pkg::DIM_W'(r_grid_width);
        end
        if (r_grid_height == '0) begin
            h_eff = lgsu_pkg::DIM_W'(1);
        end else if (32'(r_grid_height) > 32'(lgsu_pkg::MAX_HEIGHT)) begin
            h_eff = lgsu_pkg::DIM_W'(lgsu_pkg::MAX_HEIGHT);
        end else begin
            h_eff = lgsu_pkg::DIM_W'(r_grid_height);
        end
    end

    // Wrapped neighbor coordinates.
    always_comb begin
        xm = (r_x == '0) ? lgsu_pkg::X_W'(w_eff - 1'b1) : r_x - 1'b1;
        xp = (lgsu_pkg::DIM_W'(r_x) + 1'b1 == w_eff) ? '0 : r_x + 1'b1;
        ym = (r_y == '0) ? lgsu_pkg::Y_W'(h_eff - 1'b1) : r_y - 1'b1;
        yp = (lgsu_pkg::DIM_W'(r_y) + 1'b1 == h_eff) ? '0 : r_y + 1'b1;
    end

    // Memory read address.
    always_comb begin
        case (i_cmd.rd_sel)
            lgsu_pkg::SEL_CELL: rd_row = lgsu_pkg::Y_W'(r_row);
            lgsu_pkg::SEL_UP:   rd_row = ym;
            lgsu_pkg::SEL_MID:  rd_row = r_y;
            lgsu_pkg::SEL_DN:   rd_row = yp;
            default:            rd_row = r_y;
        endcase
        rd_addr = {r_cur_bank, rd_row};
    end

    // Rows never written since reset or since a generation read as dead.
    assign rd_row_eff = r_rd_vld ? r_rd_data : '0;
    assign col_idx    = lgsu_pkg::X_W'(r_col);

    // Memory write port: cell update in the current bank or new row in the other.
    always_comb begin
        mem_we  = i_cmd.row_wr || (i_cmd.cell_commit && (r_op == lgsu_pkg::OP_WRITE));
        wr_data = rd_row_eff;
        wr_data[col_idx] = r_cell_in;
        wr_addr = {r_cur_bank, lgsu_pkg::Y_W'(r_row)};
        if (i_cmd.row_wr) begin
            wr_data = r_new;
            wr_addr = {~r_cur_bank, r_y};
        end
    end

    // Neighbor count and life rule for the cell at column r_x.
    always_comb begin
        self_bit = r_mid[r_x];
        n_live   = 4'(r_up[xm]) + 4'(r_up[r_x]) + 4'(r_up[xp])
                 + 4'(r_mid[xm]) + 4'(r_mid[xp])
                 + 4'(r_dn[xm]) + 4'(r_dn[r_x]) + 4'(r_dn[xp]);
        next_bit = (n_live == 4'd3) || ((n_live == 4'd2) && self_bit);
    end

    // Grid memory.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_grid_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_grid_mem[rd_addr];
        end
    end

    // Control state: configuration, bank select, row valid bits, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= lgsu_pkg::GRID_DIM_RESET;
            r_grid_height <= lgsu_pkg::GRID_DIM_RESET;
            r_cur_bank    <= 1'b0;
            r_row_vld     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == lgsu_pkg::REG_GRID_WIDTH) begin
                    r_grid_width <= i_cfg_data;
                end else begin
                    r_grid_height <= i_cfg_data;
                end
            end
            if (i_cmd.gen_init) begin
                for (int i = 0; i < lgsu_pkg::MAX_HEIGHT; i++) begin
                    r_row_vld[{~r_cur_bank, lgsu_pkg::Y_W'(i)}] <= 1'b0;
                end
            end
            if (mem_we) begin
                r_row_vld[wr_addr] <= 1'b1;
            end
            if (i_cmd.flip) begin
                r_cur_bank <= ~r_cur_bank;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_vld <= r_row_vld[rd_addr];
        end
        if (i_cmd.load_item) begin
            r_op       <= i_op;
            r_col      <= i_col;
            r_row      <= i_row;
            r_cell_in  <= i_cell_in;
            r_res_cell <= 1'b0;
            r_count    <= '0;
        end
        if (i_cmd.cell_commit && (r_op == lgsu_pkg::OP_READ)) begin
            r_res_cell <= rd_row_eff[col_idx];
        end
        if (i_cmd.gen_init) begin
            r_y     <= '0;
            r_count <= '0;
        end
        if (i_cmd.cap_up) begin
            r_up <= rd_row_eff;
        end
        if (i_cmd.cap_mid) begin
            r_mid <= rd_row_eff;
        end
        if (i_cmd.cap_dn) begin
            r_dn  <= rd_row_eff;
            r_x   <= '0;
            r_new <= '0;
        end
        if (i_cmd.cell_step) begin
            r_new[r_x] <= next_bit;
            r_x        <= r_x + 1'b1;
            if ((next_bit != self_bit) && (r_count != lgsu_pkg::COUNT_MAX)) begin
                r_count <= r_count + 1'b1;
            end
        end
        if (i_cmd.row_wr) begin
            r_y <= r_y + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_cell  <= r_res_cell;
            r_out_count <= r_count;
        end
    end

    // Status to the controller.
    always_comb begin
        o_sts.op       = r_op;
        o_sts.in_grid  = (lgsu_pkg::DIM_W'(r_col) < w_eff) && (lgsu_pkg::DIM_W'(r_row) < h_eff);
        o_sts.x_last   = (lgsu_pkg::DIM_W'(r_x) + 1'b1 == w_eff);
        o_sts.y_last   = (lgsu_pkg::DIM_W'(r_y) + 1'b1 == h_eff);
        o_sts.out_full = r_out_valid && !i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_cell_out     = r_out_cell;
    assign o_change_count = r_out_count;

    // Assertions.
    `LGSU_ASSERT_IMP(a_step_x_in_grid, i_cmd.cell_step, (lgsu_pkg::DIM_W'(r_x) < w_eff))
    `LGSU_ASSERT_IMP(a_row_wr_y_in_grid, i_cmd.row_wr, (lgsu_pkg::DIM_W'(r_y) < h_eff))
    `LGSU_ASSERT_IMP(a_flip_after_row_wr, !$stable(r_cur_bank), $past(i_cmd.row_wr))
    `LGSU_ASSERT_NXT(a_out_load_valid, i_cmd.out_load, r_out_valid)

endmodule

[hdl/life_generation_step_unit.sv]
// ----------------------------------------------------------------------------
// Life generation step unit
// Toroidal Game of Life grid with cell write, cell read and generation step.
// ----------------------------------------------------------------------------
// A cell write or read (op 0 or 1) passes through decode, a registered cell
// read and a commit to its result; decode goes straight to the result when
// the cell lies outside the configured grid or the op is unused. A
// generation step (op 2) sweeps the configured grid row by row: each row
// takes three row reads on the single memory read port, a load step, a
// pass of the neighbor evaluator over each cell in turn and one row write.
// After each result the controller goes idle and takes the next request.
// The grid is stored one row per memory word, with a valid bit per row, so
// the store reads as all dead right after reset without a clearing pass. A
// new item is taken while the previous result still waits in the output
// register.
// ----------------------------------------------------------------------------
module life_generation_step_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [lgsu_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [lgsu_pkg::OP_W-1:0]    i_op,
    input  logic [lgsu_pkg::COORD_W-1:0] i_col,
    input  logic [lgsu_pkg::COORD_W-1:0] i_row,
    input  logic                         i_cell_in,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_cell_out,
    output logic [lgsu_pkg::CNT_W-1:0]   o_change_count
);

    lgsu_pkg::t_dp_cmd cmd;
    lgsu_pkg::t_dp_sts sts;

    // Sequencer.
    lgsu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Grid storage and evaluation.
    lgsu_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_op           (i_op),
        .i_col          (i_col),
        .i_row          (i_row),
        .i_cell_in      (i_cell_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_cell_out     (o_cell_out),
        .o_change_count (o_change_count),
        .i_cmd          (cmd),
        .o_sts          (sts)
    );

endmodule
